// File: rtl/core/ulc_pkg.sv
// Package for the ultra log-concavity sequence checker.
// Holds the transfer payload types, the controller state and command types, and shared
// constants. No dependencies.
package ulc_pkg;

	localparam int unsigned MAX_TERMS_DEF = 64;
	localparam int unsigned COEF_W        = 32;
	localparam int unsigned IDX_OUT_W     = 6;
	localparam int unsigned SUM_W         = 64;
	localparam int unsigned CNT_W         = 48;

	localparam logic [SUM_W-1:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic              last;
	} ulc_in_t;

	typedef struct packed {
		logic                 ulc_fail;
		logic [IDX_OUT_W-1:0] first_fail_index;
		logic                 equality_seen;
		logic [IDX_OUT_W-1:0] alpha;
		logic [SUM_W-1:0]     weighted_sum;
		logic [CNT_W-1:0]     polys_total;
		logic [CNT_W-1:0]     fail_total;
		logic [CNT_W-1:0]     equal_total;
		logic [SUM_W-1:0]     checksum;
		logic                 overflow;
	} ulc_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_CK_LO,
		ST_CK_HI,
		ST_LOAD
	} ulc_state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic ck_lo;
		logic ck_hi;
		logic load;
	} ulc_cmd_t;

	typedef struct packed {
		logic last_s1;
		logic out_blocked;
	} ulc_status_t;

endpackage

// File: rtl/core/ulc_ctrl.sv
// Controller of the ultra log-concavity sequence checker.
// Sequences capture, evaluation, checksum steps and result load. Depends on ulc_pkg.
module ulc_ctrl import ulc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  ulc_status_t status,
	output ulc_cmd_t    cmd
);

	ulc_state_t state_q;
	ulc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.last_s1 ? ST_CK_LO : ST_IDLE;
			end
			ST_CK_LO: begin
				cmd.ck_lo = 1'b1;
				state_d   = ST_CK_HI;
			end
			ST_CK_HI: begin
				cmd.ck_hi = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				if (!status.out_blocked) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/ulc_datapath.sv
// Datapath of the ultra log-concavity sequence checker.
// Holds the coefficient window, the test state, the sums and counters, the checksum
// partial products and the result register. Depends on ulc_pkg.
module ulc_datapath import ulc_pkg::*; #(
	parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ulc_cmd_t    cmd,
	input  ulc_in_t     item,
	output ulc_status_t status,
	output logic        result_valid,
	input  logic        result_stall,
	output ulc_out_t    result
);

	localparam int unsigned IDX_W  = $clog2(MAX_TERMS + 1);
	localparam int unsigned KP_W   = IDX_W + 1;
	localparam int unsigned TERM_W = COEF_W + KP_W;
	localparam int unsigned PROD_W = 2 * COEF_W;
	localparam int unsigned CMP_W  = PROD_W + IDX_W;
	localparam int unsigned HALF_W = SUM_W / 2;

	// Per-polynomial state.
	logic [COEF_W-1:0]    older_q, newer_q;
	logic [IDX_W-1:0]     coef_index_q;
	logic [IDX_OUT_W-1:0] highest_q;
	logic [IDX_OUT_W-1:0] conf_ff_q, pend_ff_q;
	logic                 conf_fv_q, conf_eq_q, pend_fv_q, pend_eq_q;
	logic [SUM_W-1:0]     poly_sum_q;
	logic                 dropped_q;
	// Running state.
	logic [SUM_W-1:0]     grand_sum_q;
	logic [CNT_W-1:0]     poly_cnt_q, fail_cnt_q, equal_cnt_q;

	// Capture stage.
	logic [COEF_W-1:0]    coef_s1;
	logic                 last_s1;
	logic [PROD_W-1:0]    sq_s1, oc_s1;
	logic [TERM_W-1:0]    term_s1;

	// Checksum partial products and held result.
	logic [PROD_W-1:0]    pa_q;
	logic [HALF_W-1:0]    pb_q, pc_q;
	ulc_out_t             res_q;
	ulc_out_t             out_q;
	ulc_out_t             load_val;
	logic                 out_valid_q;

	// Next values computed during evaluation.
	logic [CMP_W-1:0]     lhs, rhs;
	logic                 drop, less, equal;
	logic [IDX_OUT_W-1:0] pend_ff_n, conf_ff_n, highest_n;
	logic                 pend_fv_n, pend_eq_n, conf_fv_n, conf_eq_n;
	logic [SUM_W-1:0]     poly_sum_n, grand_sum_n;
	logic [SUM_W-1:0]     golden_sum;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			coef_s1 <= item.coefficient;
			last_s1 <= item.last;
			sq_s1   <= PROD_W'(newer_q) * PROD_W'(newer_q);
			oc_s1   <= PROD_W'(older_q) * PROD_W'(item.coefficient);
			term_s1 <= TERM_W'(item.coefficient)
				* TERM_W'(KP_W'(coef_index_q) + KP_W'(1));
		end
	end

	always_comb begin
		drop = coef_index_q >= IDX_W'(MAX_TERMS);
		lhs  = CMP_W'(sq_s1) * CMP_W'(coef_index_q - IDX_W'(1));
		rhs  = CMP_W'(oc_s1) * CMP_W'(coef_index_q);
		less  = lhs < rhs;
		equal = lhs == rhs;

		pend_fv_n   = pend_fv_q;
		pend_ff_n   = pend_ff_q;
		pend_eq_n   = pend_eq_q;
		conf_fv_n   = conf_fv_q;
		conf_ff_n   = conf_ff_q;
		conf_eq_n   = conf_eq_q;
		highest_n   = highest_q;
		poly_sum_n  = poly_sum_q;
		grand_sum_n = grand_sum_q;

		if (!drop) begin
			poly_sum_n  = poly_sum_q + SUM_W'(term_s1);
			grand_sum_n = grand_sum_q + SUM_W'(term_s1);
			if (coef_index_q >= IDX_W'(2)) begin
				if (less && !conf_fv_q && !pend_fv_q) begin
					pend_fv_n = 1'b1;
					pend_ff_n = IDX_OUT_W'(coef_index_q - IDX_W'(1));
				end
				if (equal) begin
					pend_eq_n = 1'b1;
				end
			end
			// A nonzero coefficient proves every earlier test lies below alpha.
			if (coef_s1 != '0) begin
				highest_n = IDX_OUT_W'(coef_index_q);
				if (pend_fv_n && !conf_fv_q) begin
					conf_fv_n = 1'b1;
					conf_ff_n = pend_ff_n;
				end
				if (pend_eq_n) begin
					conf_eq_n = 1'b1;
				end
				pend_fv_n = 1'b0;
				pend_ff_n = '0;
				pend_eq_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q      <= '0;
			newer_q      <= '0;
			coef_index_q <= '0;
			highest_q    <= '0;
			conf_ff_q    <= '0;
			conf_fv_q    <= 1'b0;
			conf_eq_q    <= 1'b0;
			pend_ff_q    <= '0;
			pend_fv_q    <= 1'b0;
			pend_eq_q    <= 1'b0;
			poly_sum_q   <= '0;
			dropped_q    <= 1'b0;
			grand_sum_q  <= '0;
			poly_cnt_q   <= '0;
			fail_cnt_q   <= '0;
			equal_cnt_q  <= '0;
		end else if (cmd.eval) begin
			grand_sum_q <= grand_sum_n;
			if (last_s1) begin
				poly_cnt_q   <= poly_cnt_q + CNT_W'(1);
				fail_cnt_q   <= fail_cnt_q + CNT_W'(conf_fv_n);
				equal_cnt_q  <= equal_cnt_q + CNT_W'(conf_eq_n);
				older_q      <= '0;
				newer_q      <= '0;
				coef_index_q <= '0;
				highest_q    <= '0;
				conf_ff_q    <= '0;
				conf_fv_q    <= 1'b0;
				conf_eq_q    <= 1'b0;
				pend_ff_q    <= '0;
				pend_fv_q    <= 1'b0;
				pend_eq_q    <= 1'b0;
				poly_sum_q   <= '0;
				dropped_q    <= 1'b0;
			end else begin
				if (drop) begin
					dropped_q <= 1'b1;
				end else begin
					older_q      <= newer_q;
					newer_q      <= coef_s1;
					coef_index_q <= coef_index_q + IDX_W'(1);
				end
				highest_q  <= highest_n;
				conf_ff_q  <= conf_ff_n;
				conf_fv_q  <= conf_fv_n;
				conf_eq_q  <= conf_eq_n;
				pend_ff_q  <= pend_ff_n;
				pend_fv_q  <= pend_fv_n;
				pend_eq_q  <= pend_eq_n;
				poly_sum_q <= poly_sum_n;
			end
		end
	end

	// Result fields that are final once the last coefficient has been evaluated.
	always_ff @(posedge clk) begin
		if (cmd.eval && last_s1) begin
			res_q.ulc_fail         <= conf_fv_n;
			res_q.first_fail_index <= conf_fv_n ? conf_ff_n : '0;
			res_q.equality_seen    <= conf_eq_n;
			res_q.alpha            <= highest_n;
			res_q.weighted_sum     <= poly_sum_n;
			res_q.polys_total      <= poly_cnt_q + CNT_W'(1);
			res_q.fail_total       <= fail_cnt_q + CNT_W'(conf_fv_n);
			res_q.equal_total      <= equal_cnt_q + CNT_W'(conf_eq_n);
			res_q.checksum         <= '0;
			res_q.overflow         <= drop | dropped_q;
		end
	end

	// Grand sum times the golden constant, low 64 bits, from three 32x32 products.
	always_ff @(posedge clk) begin
		if (cmd.ck_lo) begin
			pa_q <= PROD_W'(grand_sum_q[HALF_W-1:0]) * PROD_W'(GOLDEN_MULT[HALF_W-1:0]);
			pb_q <= HALF_W'(grand_sum_q[HALF_W-1:0] * GOLDEN_MULT[SUM_W-1:HALF_W]);
		end
		if (cmd.ck_hi) begin
			pc_q <= HALF_W'(grand_sum_q[SUM_W-1:HALF_W] * GOLDEN_MULT[HALF_W-1:0]);
		end
	end

	assign golden_sum = pa_q + {pb_q + pc_q, HALF_W'(0)};

	// The held fields with the finished checksum merged in.
	always_comb begin
		load_val          = res_q;
		load_val.checksum = golden_sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= load_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid       = out_valid_q;
	assign result             = out_q;
	assign status.last_s1     = last_s1;
	assign status.out_blocked = out_valid_q & result_stall;

endmodule

// File: rtl/core/ulc_sequence_checker.sv
// Ultra log-concavity sequence checker, top level. Depends on ulc_pkg, ulc_ctrl, ulc_datapath.
// The input stalls while each taken coefficient is evaluated; a coefficient marked last holds
// the input also through the ck_lo, ck_hi and load steps, plus any wait for the result register to empty.
// The result of a last coefficient becomes valid after its evaluation, ck_lo, ck_hi and load steps.
// Reset: arst_n clears the controller, all polynomial state, sums, counters and result valid.
module ulc_sequence_checker import ulc_pkg::*; #(
	parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  ulc_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output ulc_out_t result
);

	// The controller walks each coefficient through two steps. On the transfer edge the
	// datapath registers the coefficient together with the two 32x32 products that the
	// interior test needs: the square of the previous coefficient and the product of the
	// one before it with the new one. In the evaluation cycle both products are scaled by
	// the small index factors, compared over their full width, and every per-polynomial
	// register is updated. Tests are kept pending until a later nonzero coefficient shows
	// that their index lies below alpha.
	//
	// A coefficient marked last adds the ck_lo, ck_hi and load steps. The 64-bit checksum is built from three
	// 32x32 partial products spread over the ck_lo and ck_hi steps, and the result register is loaded in
	// a final step once it is free. The result register parts the two channels, so the
	// next polynomial can start while a finished result still waits to be taken.

	ulc_cmd_t    cmd;
	ulc_status_t status;

	ulc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	ulc_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Every accepted coefficient is evaluated before another one is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (item_stall && cmd.eval))
		else $error("input taken again before the previous coefficient was evaluated");

	// A waiting result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(result_valid && result_stall))
		else $error("result register loaded while still holding a stalled result");

	// A result appears only through the load step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.load))
		else $error("result valid rose without a load");

	// A loaded result carries a polynomial count one above the one before it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && $past(cmd.load, 5)) |=>
			(result.polys_total == $past(result.polys_total, 5) + CNT_W'(1)))
		else $error("polynomial count did not advance by one");

endmodule
